@@ sv/egbs_pkg.sv @@
// Package: shared types, constants and helpers of the elevation grid sampler.
package egbs_pkg;

  localparam int MAX_SIDE    = 1201;
  localparam int SIDE_W      = 11;
  localparam int BANK_SIDE   = (MAX_SIDE + 1) / 2;
  localparam int BANK_DEPTH  = BANK_SIDE * BANK_SIDE;
  localparam int BANK_AW     = $clog2(BANK_DEPTH);
  localparam int NUM_BANKS   = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] CFG_SIDE_IN_USE = 2'd0;
  localparam logic [1:0] CFG_TILE_LAT    = 2'd1;
  localparam logic [1:0] CFG_TILE_LON    = 2'd2;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic               op;
    logic               outside;
    logic [SIDE_W-1:0]  row;
    logic [SIDE_W-1:0]  col;
    logic signed [15:0] height;
    logic [15:0]        dlat;
    logic [15:0]        dlon;
  } item_t;

  typedef struct packed {
    logic empty;
    logic near_full;
    logic full;
  } queue_stat_t;

  // Address of a sample inside its parity bank.
  function automatic logic [BANK_AW-1:0] bank_addr(input logic [SIDE_W-2:0] row_half,
                                                   input logic [SIDE_W-2:0] col_half);
    bank_addr = BANK_AW'(row_half * BANK_SIDE) + BANK_AW'(col_half);
  endfunction

endpackage

@@ sv/egbs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module egbs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/egbs_front.sv @@
// Front end: takes commands, computes tile offsets and the outside check.
module egbs_front
  import egbs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               op,
  input  logic [SIDE_W-1:0]  sample_row,
  input  logic [SIDE_W-1:0]  sample_col,
  input  logic signed [15:0] sample_height,
  input  logic signed [23:0] query_lat,
  input  logic signed [24:0] query_lon,
  input  logic signed [7:0]  tile_lat,
  input  logic signed [8:0]  tile_lon,
  input  queue_stat_t        q_stat,
  output logic               busy,
  output logic               push,
  output item_t              item
);

  logic               accept;
  logic               valid;
  logic signed [24:0] dlat;
  logic signed [25:0] dlon;

  assign busy   = q_stat.near_full;
  assign accept = start && !busy;
  assign push   = valid;

  assign dlat = {query_lat[23], query_lat} - {tile_lat[7], tile_lat, 16'h0000};
  assign dlon = {query_lon[24], query_lon} - {tile_lon[8], tile_lon, 16'h0000};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= accept;
    end
    if (accept) begin
      item.op      <= op;
      item.outside <= (dlat[24:16] != '0) || (dlon[25:16] != '0);
      item.row     <= sample_row;
      item.col     <= sample_col;
      item.height  <= sample_height;
      item.dlat    <= dlat[15:0];
      item.dlon    <= dlon[15:0];
    end
  end

endmodule

@@ sv/egbs_queue.sv @@
// Short transaction queue between front end and back end.
module egbs_queue
  import egbs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  item_t       push_item,
  input  logic        pop,
  output item_t       head,
  output queue_stat_t stat
);

  item_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign head           = slots[rd_ptr];
  assign stat.empty     = (count == '0);
  assign stat.full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign stat.near_full = (count >= QCNT_W'(QUEUE_DEPTH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

@@ sv/egbs_back.sv @@
// Back end: grid position, banked sample access and bilinear blend.
module egbs_back
  import egbs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  item_t              in_item,
  input  logic [SIDE_W-1:0]  side_in_use,
  output logic               done,
  output logic signed [23:0] height_out,
  output logic               outside_tile
);

  logic [SIDE_W-1:0] m;
  always_comb begin
    if (side_in_use < SIDE_W'(2)) begin
      m = SIDE_W'(1);
    end else if (side_in_use > SIDE_W'(MAX_SIDE)) begin
      m = SIDE_W'(MAX_SIDE - 1);
    end else begin
      m = side_in_use - 1'b1;
    end
  end

  // stage 1: scale offsets by grid size
  logic                      v1, op1, out1;
  logic [26:0]               y1, x1;
  logic [SIDE_W-1:0]         row1, col1;
  logic signed [15:0]        h1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= in_valid;
    op1  <= in_item.op;
    out1 <= in_item.outside;
    y1   <= in_item.dlat * m;
    x1   <= in_item.dlon * m;
    row1 <= in_item.row;
    col1 <= in_item.col;
    h1   <= in_item.height;
  end

  // stage 2: corner rows and columns
  logic                      v2, op2, out2, wr_ok2;
  logic [SIDE_W-1:0]         srow2, nrow2, wcol2, ecol2, row2, col2;
  logic [15:0]               fx2, fy2;
  logic signed [15:0]        h2;
  logic [SIDE_W-1:0]         srow1;

  assign srow1 = m - y1[26:16];

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
    op2    <= op1;
    out2   <= out1;
    srow2  <= srow1;
    nrow2  <= srow1 - 1'b1;
    wcol2  <= x1[26:16];
    ecol2  <= x1[26:16] + 1'b1;
    fy2    <= y1[15:0];
    fx2    <= x1[15:0];
    row2   <= row1;
    col2   <= col1;
    h2     <= h1;
    wr_ok2 <= (row1 < SIDE_W'(MAX_SIDE)) && (col1 < SIDE_W'(MAX_SIDE));
  end

  // bank b holds samples with row parity b[1] and column parity b[0]
  logic [BANK_AW-1:0] waddr;
  logic [15:0]        rdata [NUM_BANKS];

  assign waddr = bank_addr(row2[SIDE_W-1:1], col2[SIDE_W-1:1]);

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    logic [SIDE_W-1:0]  r_sel, c_sel;
    logic [BANK_AW-1:0] raddr;
    logic               we;
    assign r_sel = (srow2[0] == 1'(b >> 1)) ? srow2 : nrow2;
    assign c_sel = (wcol2[0] == 1'(b)) ? wcol2 : ecol2;
    assign raddr = bank_addr(r_sel[SIDE_W-1:1], c_sel[SIDE_W-1:1]);
    assign we    = v2 && (op2 == OP_LOAD) && wr_ok2 && ({row2[0], col2[0]} == 2'(b));
    egbs_ram #(.WIDTH(16), .DEPTH(BANK_DEPTH)) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (waddr),
      .wdata (h2),
      .raddr (raddr),
      .rdata (rdata[b])
    );
  end

  // stage 3: read data arrives
  logic        v3, op3, out3, spar3, wpar3;
  logic [15:0] fx3, fy3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else     v3 <= v2;
    op3   <= op2;
    out3  <= out2;
    spar3 <= srow2[0];
    wpar3 <= wcol2[0];
    fx3   <= fx2;
    fy3   <= fy2;
  end

  // stage 4: horizontal weight products
  logic signed [15:0] sw, se, nw, ne;
  logic signed [17:0] wx3, fxs3;
  logic               v4, op4, out4;
  logic [15:0]        fy4;
  logic signed [33:0] p_sw, p_se, p_nw, p_ne;

  assign sw   = $signed(rdata[{spar3, wpar3}]);
  assign se   = $signed(rdata[{spar3, ~wpar3}]);
  assign nw   = $signed(rdata[{~spar3, wpar3}]);
  assign ne   = $signed(rdata[{~spar3, ~wpar3}]);
  assign wx3  = $signed(18'h10000 - {2'b00, fx3});
  assign fxs3 = $signed({2'b00, fx3});

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else     v4 <= v3;
    op4  <= op3;
    out4 <= out3;
    fy4  <= fy3;
    p_sw <= sw * wx3;
    p_se <= se * fxs3;
    p_nw <= nw * wx3;
    p_ne <= ne * fxs3;
  end

  // stage 5: row blends
  logic               v5, op5, out5;
  logic [15:0]        fy5;
  logic signed [33:0] south5, north5;

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else     v5 <= v4;
    op5    <= op4;
    out5   <= out4;
    fy5    <= fy4;
    south5 <= p_sw + p_se;
    north5 <= p_nw + p_ne;
  end

  // stage 6: vertical weight products
  logic               v6, op6, out6;
  logic signed [17:0] wy5, fys5;
  logic signed [51:0] ps6, pn6;

  assign wy5  = $signed(18'h10000 - {2'b00, fy5});
  assign fys5 = $signed({2'b00, fy5});

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else     v6 <= v5;
    op6  <= op5;
    out6 <= out5;
    ps6  <= south5 * wy5;
    pn6  <= north5 * fys5;
  end

  // stage 7: sum, round half up to Q16.8
  logic signed [51:0] rsum;
  assign rsum = ps6 + pn6 + 52'sd8388608;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v6 && (op6 == OP_QUERY);
    end
    outside_tile <= out6;
    height_out   <= out6 ? 24'sd0 : rsum[47:24];
  end

endmodule

@@ sv/elevation_grid_bilinear_sampler.sv @@
// Top level of the elevation grid bilinear sampler.
//
// Commands enter on start/op and the payload ports; a command is taken at a
// rising edge with start high and busy low. op = load writes one signed
// 16-bit sample at (sample_row, sample_col), row 0 being the northern edge;
// writes at or beyond the tile maximum are dropped and return nothing.
// op = query (Q8.16 latitude, Q9.16 longitude) returns one transaction:
// done is high for exactly one cycle with height_out (Q16.8, rounded) and
// outside_tile. An off-tile query returns outside_tile = 1 and height 0.
// The path to done runs through the front register (loaded at the edge that
// takes the command), a queue slot and seven back-end stages.
// Throughput: one command per cycle while busy is low; samples sit in four
// row/column parity banks, so the four corners of a query are read from
// separate memories in the same cycle.
// busy rises only when the front queue is nearly full, which the always
// draining back end does not allow in steady state.
// The receiver cannot stall: done is a strobe and must be taken as it comes.
// Configuration: cfg_we/cfg_index/cfg_data write side_in_use, tile_lat,
// tile_lon while idle. Reset (rst, synchronous) clears control state and
// sets side 1201 and origin 0/0; sample memory is not cleared and a query
// must only touch samples already loaded.
module elevation_grid_bilinear_sampler
  import egbs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               op,
  input  logic [SIDE_W-1:0]  sample_row,
  input  logic [SIDE_W-1:0]  sample_col,
  input  logic signed [15:0] sample_height,
  input  logic signed [23:0] query_lat,
  input  logic signed [24:0] query_lon,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [SIDE_W-1:0]  cfg_data,
  output logic               done,
  output logic signed [23:0] height_out,
  output logic               outside_tile
);

  // configuration registers
  logic [SIDE_W-1:0] side_in_use;
  logic signed [7:0] tile_lat;
  logic signed [8:0] tile_lon;

  always_ff @(posedge clk) begin
    if (rst) begin
      side_in_use <= SIDE_W'(MAX_SIDE);
      tile_lat    <= '0;
      tile_lon    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SIDE_IN_USE: side_in_use <= cfg_data;
        CFG_TILE_LAT:    tile_lat    <= cfg_data[7:0];
        CFG_TILE_LON:    tile_lon    <= cfg_data[8:0];
        default:         ;
      endcase
    end
  end

  logic        q_push;
  item_t       q_in;
  item_t       q_head;
  queue_stat_t q_stat;
  logic        q_pop;

  // back end never stalls, so it pops the queue every cycle that it is not empty
  assign q_pop = !q_stat.empty;

  egbs_front u_front (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .op            (op),
    .sample_row    (sample_row),
    .sample_col    (sample_col),
    .sample_height (sample_height),
    .query_lat     (query_lat),
    .query_lon     (query_lon),
    .tile_lat      (tile_lat),
    .tile_lon      (tile_lon),
    .q_stat        (q_stat),
    .busy          (busy),
    .push          (q_push),
    .item          (q_in)
  );

  egbs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  egbs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (q_pop),
    .in_item      (q_head),
    .side_in_use  (side_in_use),
    .done         (done),
    .height_out   (height_out),
    .outside_tile (outside_tile)
  );

  // queue must never be written while full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full)
    else $error("queue overflow");

  // off-tile results carry zero height
  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    (done && outside_tile) |-> (height_out == 24'sd0))
    else $error("outside result with nonzero height");

  // busy only when the queue actually holds transactions
  a_busy_nonempty: assert property (@(posedge clk) disable iff (rst)
    busy |-> !q_stat.empty)
    else $error("busy with empty queue");

endmodule

@@ tb/sv/elevation_grid_bilinear_sampler_tb.sv @@
// Self-checking testbench of the elevation grid bilinear sampler.
`timescale 1ns / 1ps

module elevation_grid_bilinear_sampler_tb;
  import egbs_pkg::*;

  // Expected height transactions, in command order.
  typedef struct {
    logic signed [23:0] height;
    logic               outside;
  } height_result_t;

  // Scoreboard: own copy of the tile and the registers, plus the queue of
  // results still owed by the block.
  class height_scoreboard;
    int unsigned        side_reg;
    logic signed [7:0]  lat_reg;
    logic signed [8:0]  lon_reg;
    logic signed [15:0] tile_store [int unsigned];
    height_result_t     pending [$];
    int                 mismatches;

    function new();
      side_reg = MAX_SIDE;
      lat_reg = '0;
      lon_reg = '0;
      mismatches = 0;
    endfunction

    function void configure(logic [1:0] index, logic [SIDE_W-1:0] data);
      case (index)
        CFG_SIDE_IN_USE: side_reg = data;
        CFG_TILE_LAT:    lat_reg = data[7:0];
        CFG_TILE_LON:    lon_reg = data[8:0];
        default: ;
      endcase
    endfunction

    // Grid cell of a query: southern row and western column, fractions.
    function automatic bit locate(logic signed [23:0] qlat, logic signed [24:0] qlon,
                                  output int unsigned srow, output int unsigned wcol,
                                  output longint fy, output longint fx);
      longint dlat, dlon, y, x;
      int unsigned m;
      dlat = longint'(qlat) - longint'(lat_reg) * 65536;
      dlon = longint'(qlon) - longint'(lon_reg) * 65536;
      srow = 0; wcol = 0; fy = 0; fx = 0;
      if (dlat < 0 || dlat >= 65536 || dlon < 0 || dlon >= 65536) return 1'b0;
      m = (side_reg < 2) ? 1 : (side_reg > MAX_SIDE) ? MAX_SIDE - 1 : side_reg - 1;
      y = dlat * m;
      x = dlon * m;
      srow = m - int'(y >> 16);
      wcol = int'(x >> 16);
      fy = y & 16'hffff;
      fx = x & 16'hffff;
      return 1'b1;
    endfunction

    function automatic longint sample(int unsigned row, int unsigned col);
      int unsigned key;
      key = row * MAX_SIDE + col;
      return tile_store.exists(key) ? longint'(tile_store[key]) : 0;
    endfunction

    function void note_command(logic cmd, logic [SIDE_W-1:0] row, logic [SIDE_W-1:0] col,
                               logic signed [15:0] h, logic signed [23:0] qlat,
                               logic signed [24:0] qlon);
      height_result_t r;
      int unsigned srow, wcol;
      longint fy, fx, south, north, sum;
      if (cmd == OP_LOAD) begin
        if (row < MAX_SIDE && col < MAX_SIDE) tile_store[row * MAX_SIDE + col] = h;
        return;
      end
      if (!locate(qlat, qlon, srow, wcol, fy, fx)) begin
        r.height = '0;
        r.outside = 1'b1;
      end else begin
        south = sample(srow, wcol) * (65536 - fx) + sample(srow, wcol + 1) * fx;
        north = sample(srow - 1, wcol) * (65536 - fx) + sample(srow - 1, wcol + 1) * fx;
        sum = south * (65536 - fy) + north * fy;
        // Round half up: arithmetic shift floors toward minus infinity.
        sum = (sum + (64'sd1 <<< 23)) >>> 24;
        r.height = sum[23:0];
        r.outside = 1'b0;
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic signed [23:0] h, logic o);
      height_result_t r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: height %0d outside %0b", h, o);
        return;
      end
      r = pending.pop_front();
      if (h !== r.height || o !== r.outside) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: height %0d/%0d outside %0b/%0b (exp/act)",
                   r.height, h, r.outside, o);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic               op = OP_LOAD;
  logic [SIDE_W-1:0]  sample_row = '0;
  logic [SIDE_W-1:0]  sample_col = '0;
  logic signed [15:0] sample_height = '0;
  logic signed [23:0] query_lat = '0;
  logic signed [24:0] query_lon = '0;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = CFG_SIDE_IN_USE;
  logic [SIDE_W-1:0]  cfg_data = '0;
  logic               done;
  logic signed [23:0] height_out;
  logic               outside_tile;

  height_scoreboard sb = new();
  int burst_left = 0;

  always #2 clk = ~clk;

  elevation_grid_bilinear_sampler dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .sample_row(sample_row), .sample_col(sample_col), .sample_height(sample_height),
    .query_lat(query_lat), .query_lon(query_lon),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .height_out(height_out), .outside_tile(outside_tile)
  );

  // Results are strobes; take each one at the edge that ends its cycle.
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(height_out, outside_tile);
  end

  // One command transaction; inputs move at the falling edge and the
  // transaction counts at the first rising edge with busy low. Between
  // bursts start drops for a random gap, which may be zero.
  task automatic send(logic cmd, logic [SIDE_W-1:0] row, logic [SIDE_W-1:0] col,
                      logic signed [15:0] h, logic signed [23:0] qlat,
                      logic signed [24:0] qlon);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        start = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    start = 1'b1;
    op = cmd;
    sample_row = row;
    sample_col = col;
    sample_height = h;
    query_lat = qlat;
    query_lon = qlon;
    do @(posedge clk); while (busy);
    sb.note_command(cmd, row, col, h, qlat, qlon);
  endtask

  task automatic load(logic [SIDE_W-1:0] row, logic [SIDE_W-1:0] col, logic signed [15:0] h);
    send(OP_LOAD, row, col, h, $urandom, $urandom);
  endtask

  // Query; any corner not yet in the tile gets a random sample first so
  // that no unwritten entry is ever read.
  task automatic query(logic signed [23:0] qlat, logic signed [24:0] qlon);
    int unsigned srow, wcol;
    longint fy, fx;
    if (sb.locate(qlat, qlon, srow, wcol, fy, fx)) begin
      for (int dr = 0; dr < 2; dr++)
        for (int dc = 0; dc < 2; dc++)
          if (!sb.tile_store.exists((srow - dr) * MAX_SIDE + wcol + dc))
            load(srow - dr, wcol + dc, $urandom);
    end
    send(OP_QUERY, $urandom, $urandom, $urandom, qlat, qlon);
  endtask

  // Query at an offset from the tile's south-west corner in Q0.16 degrees.
  task automatic query_at(int dlat, int dlon);
    query(24'(int'(sb.lat_reg) * 65536 + dlat), 25'(int'(sb.lon_reg) * 65536 + dlon));
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    burst_left = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_config(int side, int lat, int lon);
    drain();
    cfg_we = 1'b1;
    cfg_index = CFG_SIDE_IN_USE; cfg_data = SIDE_W'(side);
    sb.configure(cfg_index, cfg_data);
    @(negedge clk);
    cfg_index = CFG_TILE_LAT; cfg_data = SIDE_W'(lat);
    sb.configure(cfg_index, cfg_data);
    @(negedge clk);
    cfg_index = CFG_TILE_LON; cfg_data = SIDE_W'(lon);
    sb.configure(cfg_index, cfg_data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Mostly in-tile queries with random loads mixed in.
  task automatic random_items(int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 20)
        load($urandom_range(0, sb.side_reg > MAX_SIDE ? MAX_SIDE - 1 :
                                (sb.side_reg < 2 ? 1 : sb.side_reg - 1)),
             $urandom_range(0, MAX_SIDE - 1), $urandom);
      else if (pick < 27)
        load($urandom, $urandom, $urandom);
      else if (pick < 37)
        query($urandom, $urandom);
      else if (pick < 45)
        query_at($urandom_range(0, 1) ? -$urandom_range(1, 3) : 65536 + $urandom_range(0, 3),
                 $urandom_range(0, 65535));
      else if (pick < 52)
        query_at(0, $urandom_range(0, 65535));
      else
        query_at($urandom_range(0, 65535), $urandom_range(0, 65535));
      if (i == count / 2 && $urandom_range(0, 2) == 0) drain();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: reset registers, extremes of every field, grid lines, edges.
    load(0, 0, 16'sh7fff);
    load(1200, 1200, 16'sh8000);
    load(11'h7ff, 11'h7ff, 16'sh1234);
    load(1201, 0, -16'sd1);
    query_at(0, 0);
    query_at(65535, 65535);
    query_at(0, 65535);
    query_at(65535, 0);
    query_at(-1, 0);
    query_at(0, 65536);
    query(24'h800000, 25'h1000000);
    query(24'h7fffff, 25'h0ffffff);
    drain();

    write_config(2, -128, -256);
    load(0, 0, 16'sh7fff); load(0, 1, 16'sh7fff);
    load(1, 0, 16'sh7fff); load(1, 1, 16'sh7fff);
    query_at(32768, 32768);
    query_at(65535, 65535);
    query(24'h800000, 25'h1000000);
    random_items(40);

    write_config(5, 127, 255);
    query_at(16384, 49152);
    query_at(65535, 65535);
    random_items(40);

    write_config(0, -90, -180);
    random_items(35);
    write_config(1201, 89, 179);
    random_items(30);
    write_config(17, 3, -7);
    random_items(40);
    write_config(2047, -1, 0);
    random_items(25);
    write_config(1, 45, -100);
    random_items(50);
    write_config($urandom_range(2, 64), $urandom_range(0, 255), $urandom_range(0, 511));
    random_items(35);

    drain();
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("elevation_grid_bilinear_sampler test passed");
    end else begin
      $display("elevation_grid_bilinear_sampler test failed");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("elevation_grid_bilinear_sampler test failed");
    $finish;
  end

endmodule
